FILE: rtl/core/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the gyro tap gesture detector.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int RateW   = 16;
  localparam int ThrW    = 15;
  localparam int GapW    = 16;
  localparam int TimeW   = 32;
  localparam int StatusW = 8;
  localparam int CfgIdxW = 8;
  localparam int CfgW    = 16;
  localparam int TapBit  = 2;

  localparam logic [CfgIdxW-1:0] CFG_RATE_THRESHOLD = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_TAP_GAP = 8'd1;

  localparam logic [ThrW-1:0] RATE_THRESHOLD_RST = 15'd100;
  localparam logic [GapW-1:0] DOUBLE_TAP_GAP_RST = 16'd300;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  typedef enum logic [2:0] {
    GC_TAP     = 3'd0,
    GC_DOUBLE  = 3'd1,
    GC_RIGHT   = 3'd2,
    GC_LEFT    = 3'd3,
    GC_UP      = 3'd4,
    GC_DOWN    = 3'd5
  } gesture_t;

  typedef struct packed {
    logic fire;
    logic neg;
  } axis_hit_t;

  typedef struct packed {
    logic fire;
    logic dbl;
  } tap_hit_t;

  typedef struct packed {
    gesture_t code;
    logic     last;
  } result_t;

endpackage

FILE: rtl/core/gtg_axis.sv
// ----------------------------------------------------------------------------
// gtg_axis
// One gyro axis: sample window, running sum and threshold compare.
// ----------------------------------------------------------------------------
module gtg_axis #(
  parameter int WINDOW = 8,
  parameter int PW     = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              sample_en,
  input  logic [PW-1:0]                     pos,
  input  logic signed [gtg_pkg::RateW-1:0]  rate,
  input  logic [gtg_pkg::ThrW-1:0]          thr,
  output gtg_pkg::axis_hit_t                hit
);
  import gtg_pkg::*;

  localparam int SW = RateW + 1 + $clog2(WINDOW + 1);

  logic signed [RateW-1:0] win_r [WINDOW];
  logic signed [SW-1:0]    sum_r;
  logic signed [SW-1:0]    sum_nxt;
  logic signed [SW-1:0]    lim;
  logic signed [RateW-1:0] old;

  assign old     = win_r[pos];
  assign sum_nxt = sum_r - {{(SW-RateW){old[RateW-1]}}, old}
                         + {{(SW-RateW){rate[RateW-1]}}, rate};
  // trunc(sum / WINDOW) > thr  <=>  sum >= (thr + 1) * WINDOW, mirrored below
  assign lim     = SW'((SW'(thr) + SW'(1)) * SW'(WINDOW));

  always_comb begin
    hit.fire = (sum_nxt >= lim) || (sum_nxt <= -lim);
    hit.neg  = (sum_nxt <= -lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else if (sample_en) begin
      if (hit.fire) begin
        sum_r <= '0;
        for (int i = 0; i < WINDOW; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        sum_r      <= sum_nxt;
        win_r[pos] <= rate;
      end
    end
  end

endmodule

FILE: rtl/core/gtg_tap.sv
// ----------------------------------------------------------------------------
// gtg_tap
// Single and double tap detection from the interrupt status byte.
// ----------------------------------------------------------------------------
module gtg_tap (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tap_en,
  input  logic [gtg_pkg::StatusW-1:0]  tap_status,
  input  logic [gtg_pkg::TimeW-1:0]    time_ms,
  input  logic [gtg_pkg::GapW-1:0]     gap,
  output gtg_pkg::tap_hit_t            hit
);
  import gtg_pkg::*;

  logic             tap_pending_r;
  logic [TimeW-1:0] last_tap_time_r;
  logic [TimeW-1:0] elapsed;

  // elapsed time wraps with the tick counter
  assign elapsed = time_ms - last_tap_time_r;

  always_comb begin
    hit.fire = tap_status[TapBit];
    hit.dbl  = tap_pending_r && (elapsed < {{(TimeW-GapW){1'b0}}, gap});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_pending_r   <= 1'b0;
      last_tap_time_r <= '0;
    end else if (tap_en && hit.fire) begin
      if (hit.dbl) begin
        tap_pending_r <= 1'b0;
      end else begin
        tap_pending_r   <= 1'b1;
        last_tap_time_r <= time_ms;
      end
    end
  end

endmodule

FILE: rtl/core/gtg_out_fifo.sv
// ----------------------------------------------------------------------------
// gtg_out_fifo
// Four-entry result queue, takes up to two results per cycle.
// ----------------------------------------------------------------------------
module gtg_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  gtg_pkg::result_t  push0,
  input  gtg_pkg::result_t  push1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output gtg_pkg::result_t  out_data
);
  import gtg_pkg::*;

  result_t    mem_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      count_r  <= count_r + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

endmodule

FILE: rtl/core/gyro_tap_gesture_detector.sv
// ----------------------------------------------------------------------------
// gyro_tap_gesture_detector
// Gyro swipe/tilt and tap/double-tap gesture detector with stream ports.
// ----------------------------------------------------------------------------
// path: an accepted transaction waits in the input register until the result
//   queue has room, then its gestures are pushed there and show on out_tvalid
// throughput: one input per cycle; the input stage waits while the result
//   queue holds more than two gestures, so out_tready sets the long-run rate
// reset: synchronous active-low rst_n clears windows, sums, tap state, queue
//   state and the input valid flag and loads config defaults, no clearing pass
module gyro_tap_gesture_detector #(
  parameter int WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // rate_y[15:0], rate_z[31:16], tap_status[39:32],
                                 // time_ms[71:40]
  input  logic [0:0]  in_tuser,  // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // gesture_code[2:0], zero pad[7:3]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gtg_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gtg_pkg::CfgW-1:0]    cfg_data
);
  import gtg_pkg::*;

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic               in_valid_r;
  logic               cmd_r;
  logic [71:0]        data_r;
  logic [ThrW-1:0]    thr_r;
  logic [GapW-1:0]    gap_r;
  logic [PW-1:0]      pos_r;
  logic               room2;
  logic               fire;
  logic               sample_en;
  logic               tap_en;
  axis_hit_t          y_hit;
  axis_hit_t          z_hit;
  tap_hit_t           t_hit;
  logic [1:0]         push_cnt;
  result_t            push0;
  result_t            push1;
  result_t            head;

  assign fire      = in_valid_r && room2;
  assign in_tready = !in_valid_r || room2;
  assign sample_en = fire && (cmd_r == CMD_SAMPLE);
  assign tap_en    = fire && (cmd_r == CMD_TAP);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tuser[0];
      data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= RATE_THRESHOLD_RST;
      gap_r <= DOUBLE_TAP_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RATE_THRESHOLD) begin
        thr_r <= cfg_data[ThrW-1:0];
      end else if (cfg_index == CFG_DOUBLE_TAP_GAP) begin
        gap_r <= cfg_data[GapW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (sample_en) begin
      pos_r <= (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + PW'(1);
    end
  end

  gtg_axis #(.WINDOW(WINDOW), .PW(PW)) u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .pos       (pos_r),
    .rate      (data_r[15:0]),
    .thr       (thr_r),
    .hit       (y_hit)
  );

  gtg_axis #(.WINDOW(WINDOW), .PW(PW)) u_axis_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .pos       (pos_r),
    .rate      (data_r[31:16]),
    .thr       (thr_r),
    .hit       (z_hit)
  );

  gtg_tap u_tap (
    .clk        (clk),
    .rst_n      (rst_n),
    .tap_en     (tap_en),
    .tap_status (data_r[39:32]),
    .time_ms    (data_r[71:40]),
    .gap        (gap_r),
    .hit        (t_hit)
  );

  // y gesture goes first when both axes fire
  always_comb begin
    gesture_t y_code;
    gesture_t z_code;
    y_code     = y_hit.neg ? GC_LEFT : GC_RIGHT;
    z_code     = z_hit.neg ? GC_DOWN : GC_UP;
    push_cnt   = 2'd0;
    push0.code = GC_TAP;
    push0.last = 1'b1;
    push1.code = z_code;
    push1.last = 1'b1;
    if (sample_en) begin
      priority if (y_hit.fire && z_hit.fire) begin
        push_cnt   = 2'd2;
        push0.code = y_code;
        push0.last = 1'b0;
      end else if (y_hit.fire) begin
        push_cnt   = 2'd1;
        push0.code = y_code;
      end else if (z_hit.fire) begin
        push_cnt   = 2'd1;
        push0.code = z_code;
      end
    end else if (tap_en && t_hit.fire) begin
      push_cnt   = 2'd1;
      push0.code = t_hit.dbl ? GC_DOUBLE : GC_TAP;
    end
  end

  gtg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tdata = {5'b00000, head.code};
  assign out_tlast = head.last;

endmodule

FILE: rtl/core/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Port-level checks for the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module gtg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import gtg_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // only defined gesture codes leave the block
  a_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] == 5'd0) && (out_tdata[2:0] <= 3'(GC_DOWN)))
    else $error("undefined gesture code");

  // a double tap or tap stands alone, so it always ends its run
  a_tap_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[2:0] == 3'(GC_TAP)) || (out_tdata[2:0] == 3'(GC_DOUBLE)))
      |-> out_tlast)
    else $error("tap gesture without last");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue or input stage not empty after reset");

endmodule

bind gyro_tap_gesture_detector gtg_checker u_gtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
